// ===== hdl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg: shared types and constants of the timed shutter positioner
// Field widths, full-scale value, register map and configuration bundle.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Field widths
  localparam int unsigned POS_W       = 13;
  localparam int unsigned TRAVEL_W    = 20;
  localparam int unsigned EXTRA_W     = 8;
  localparam int unsigned TIME_W      = 21;
  localparam int unsigned PROD_W      = TRAVEL_W + POS_W;
  localparam int unsigned SCALE_SHIFT = 12;

  // Full scale position (fully open) and saturation limit of the timers
  localparam logic [POS_W-1:0]  FULL_POS = POS_W'(4096);
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // Register reset values
  localparam logic [TRAVEL_W-1:0] TRAVEL_RST = TRAVEL_W'(20000);
  localparam logic [EXTRA_W-1:0]  EXTRA_RST  = EXTRA_W'(3);

  // Configuration port
  localparam int unsigned APB_ADDR_W = 4;
  localparam int unsigned APB_DATA_W = 32;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_UP_TRAVEL   = 2'd0;
  localparam reg_idx_t REG_DOWN_TRAVEL = 2'd1;
  localparam reg_idx_t REG_ZERO_EXTRA  = 2'd2;

  // Configuration bundle handed to the core
  typedef struct packed {
    logic [TRAVEL_W-1:0] up_full_travel_ms;
    logic [TRAVEL_W-1:0] down_full_travel_ms;
    logic [EXTRA_W-1:0]  zeroing_extra_ms;
  } cfg_t;

endpackage

// ===== hdl/tsp_ram.sv =====
// ----------------------------------------------------------------------------
// tsp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module tsp_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tsp_mul.sv =====
// ----------------------------------------------------------------------------
// tsp_mul: bit-serial shift-add multiplier
// Takes one multiplier bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tsp_mul #(
  parameter int unsigned A_W = 20,
  parameter int unsigned B_W = 13
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] product_o
);

  localparam int unsigned P_W   = A_W + B_W;
  localparam int unsigned CNT_W = $clog2(B_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [A_W-1:0]   a_q, a_d;
  logic [B_W-1:0]   b_q, b_d;
  logic [P_W-1:0]   acc_q, acc_d;
  logic [P_W-1:0]   addend;

  // One shift-add step per cycle
  always_comb begin
    addend = b_q[B_W-1] ? P_W'(a_q) : '0;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(B_W);
      a_d    = a_i;
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = {acc_q[P_W-2:0], 1'b0} + addend;
      b_d   = {b_q[B_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

// ===== hdl/tsp_cfg.sv =====
// ----------------------------------------------------------------------------
// tsp_cfg: configuration register file
// APB-style access to the travel times and the zeroing extra time.
// ----------------------------------------------------------------------------
module tsp_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tsp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tsp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  output tsp_pkg::cfg_t                   cfg_o
);

  import tsp_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = paddr[3:2];
  assign wr_en = psel && penable && pwrite;

  // Register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_UP_TRAVEL:   cfg_d.up_full_travel_ms   = pwdata[TRAVEL_W-1:0];
        REG_DOWN_TRAVEL: cfg_d.down_full_travel_ms = pwdata[TRAVEL_W-1:0];
        REG_ZERO_EXTRA:  cfg_d.zeroing_extra_ms    = pwdata[EXTRA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.up_full_travel_ms   <= TRAVEL_RST;
      cfg_q.down_full_travel_ms <= TRAVEL_RST;
      cfg_q.zeroing_extra_ms    <= EXTRA_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Register read
  always_comb begin
    unique case (idx)
      REG_UP_TRAVEL:   prdata = APB_DATA_W'(cfg_q.up_full_travel_ms);
      REG_DOWN_TRAVEL: prdata = APB_DATA_W'(cfg_q.down_full_travel_ms);
      REG_ZERO_EXTRA:  prdata = APB_DATA_W'(cfg_q.zeroing_extra_ms);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

endmodule

// ===== hdl/timed_shutter_positioner_core.sv =====
// ----------------------------------------------------------------------------
// timed_shutter_positioner_core: open-loop timed shutter positioner
// Enqueue and plain tick transactions give their result in the cycle after
// acceptance; a tick that starts a run gives it after the POP state and the
// 13-step serial multiplier that computes the run time (straight after POP
// when the target equals the position). A new transaction may be accepted
// in the result cycle. Async active-low reset: closed, idle, queue empty.
// ----------------------------------------------------------------------------
module timed_shutter_positioner_core #(
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Item channel
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [tsp_pkg::POS_W-1:0]       target_position_i,
  // Result channel
  output logic                            result_valid_o,
  output logic                            motor_up_o,
  output logic                            motor_down_o,
  output logic [tsp_pkg::POS_W-1:0]       position_o,
  output logic                            busy_res_o,
  output logic                            done_res_o,
  output logic                            dropped_o,
  output logic [CNT_W-1:0]                queue_count_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tsp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [tsp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tsp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import tsp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_FULL = CNT_W'(QUEUE_DEPTH);

  // Sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  cfg_t cfg;

  logic [1:0]        st_q, st_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [POS_W-1:0]  act_q, act_d;
  logic              run_q, run_d;
  logic              up_q, up_d;
  logic              down_q, down_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [TIME_W-1:0] run_time_q, run_time_d;
  logic              endstop_q, endstop_d;
  logic              strobe_q, strobe_d;
  logic              done_q, done_d;
  logic              drop_q, drop_d;

  logic              accept;
  logic [POS_W-1:0]  enq_tgt;
  logic              ram_we;
  logic [POS_W-1:0]  pop_tgt;
  logic              mul_start;
  logic [TRAVEL_W-1:0] mul_a;
  logic [POS_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic [TIME_W-1:0] elapsed_inc;
  logic [TIME_W:0]   run_sum;

  assign accept = start && !busy;
  assign busy   = (st_q != ST_IDLE);

  // Clamp targets above full scale
  assign enq_tgt = (target_position_i > FULL_POS) ? FULL_POS : target_position_i;
  assign ram_we  = accept && kind_i && (fill_q != FILL_FULL);

  // Saturating elapsed time
  assign elapsed_inc = (elapsed_q == TIME_MAX) ? elapsed_q : elapsed_q + TIME_W'(1);

  // Run time: scaled product plus zeroing time at an end stop, saturated
  assign run_sum = {1'b0, mul_prod[PROD_W-1:SCALE_SHIFT]}
                 + (endstop_q ? (TIME_W+1)'(cfg.zeroing_extra_ms) : '0);

  // Sequencer and run state
  always_comb begin
    st_d       = st_q;
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    fill_d     = fill_q;
    pos_d      = pos_q;
    act_d      = act_q;
    run_d      = run_q;
    up_d       = up_q;
    down_d     = down_q;
    elapsed_d  = elapsed_q;
    run_time_d = run_time_q;
    endstop_d  = endstop_q;
    strobe_d   = 1'b0;
    done_d     = done_q;
    drop_d     = drop_q;
    mul_start  = 1'b0;
    mul_a      = cfg.up_full_travel_ms;
    mul_b      = '0;

    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          done_d = 1'b0;
          drop_d = 1'b0;
          if (kind_i) begin
            // Enqueue transaction
            strobe_d = 1'b1;
            if (fill_q == FILL_FULL) begin
              drop_d = 1'b1;
            end else begin
              wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
              fill_d   = fill_q + CNT_W'(1);
            end
          end else if (!run_q) begin
            // Idle tick: pop the next target if any
            if (fill_q != '0) begin
              st_d = ST_POP;
            end else begin
              strobe_d = 1'b1;
            end
          end else begin
            // Tick during a run: advance time and check for the end
            strobe_d  = 1'b1;
            elapsed_d = elapsed_inc;
            if (act_q == pos_q) begin
              done_d = 1'b1;
              run_d  = 1'b0;
            end else if (elapsed_inc > run_time_q) begin
              done_d = 1'b1;
              run_d  = 1'b0;
              up_d   = 1'b0;
              down_d = 1'b0;
              pos_d  = act_q;
            end
          end
        end
      end

      ST_POP: begin
        // Queue head is on the RAM read port; start the run
        rd_ptr_d  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
        fill_d    = fill_q - CNT_W'(1);
        act_d     = pop_tgt;
        run_d     = 1'b1;
        elapsed_d = '0;
        if (pop_tgt > pos_q) begin
          up_d      = 1'b1;
          endstop_d = (pop_tgt == FULL_POS);
          mul_a     = cfg.up_full_travel_ms;
          mul_b     = pop_tgt - pos_q;
          mul_start = 1'b1;
          st_d      = ST_MUL;
        end else if (pop_tgt < pos_q) begin
          down_d    = 1'b1;
          endstop_d = (pop_tgt == '0);
          mul_a     = cfg.down_full_travel_ms;
          mul_b     = pos_q - pop_tgt;
          mul_start = 1'b1;
          st_d      = ST_MUL;
        end else begin
          strobe_d = 1'b1;
          st_d     = ST_IDLE;
        end
      end

      ST_MUL: begin
        if (mul_done) begin
          run_time_d = run_sum[TIME_W] ? TIME_MAX : run_sum[TIME_W-1:0];
          strobe_d   = 1'b1;
          st_d       = ST_IDLE;
        end
      end

      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      rd_ptr_q   <= '0;
      wr_ptr_q   <= '0;
      fill_q     <= '0;
      pos_q      <= '0;
      act_q      <= '0;
      run_q      <= 1'b0;
      up_q       <= 1'b0;
      down_q     <= 1'b0;
      elapsed_q  <= '0;
      run_time_q <= '0;
      endstop_q  <= 1'b0;
      strobe_q   <= 1'b0;
      done_q     <= 1'b0;
      drop_q     <= 1'b0;
    end else begin
      st_q       <= st_d;
      rd_ptr_q   <= rd_ptr_d;
      wr_ptr_q   <= wr_ptr_d;
      fill_q     <= fill_d;
      pos_q      <= pos_d;
      act_q      <= act_d;
      run_q      <= run_d;
      up_q       <= up_d;
      down_q     <= down_d;
      elapsed_q  <= elapsed_d;
      run_time_q <= run_time_d;
      endstop_q  <= endstop_d;
      strobe_q   <= strobe_d;
      done_q     <= done_d;
      drop_q     <= drop_d;
    end
  end

  // Target queue storage
  tsp_ram #(
    .WIDTH (POS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (enq_tgt),
    .raddr_i (rd_ptr_q),
    .rdata_o (pop_tgt)
  );

  // Travel time multiplier
  tsp_mul #(
    .A_W (TRAVEL_W),
    .B_W (POS_W)
  ) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_a),
    .b_i       (mul_b),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // Configuration registers
  tsp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Result ports show the state left by the transaction
  assign result_valid_o = strobe_q;
  assign motor_up_o     = up_q;
  assign motor_down_o   = down_q;
  assign position_o     = pos_q;
  assign busy_res_o     = run_q;
  assign done_res_o     = done_q;
  assign dropped_o      = drop_q;
  assign queue_count_o  = fill_q;

endmodule

// ===== hdl/tsp_checker.sv =====
// ----------------------------------------------------------------------------
// tsp_checker: port-level checks of the timed shutter positioner
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module tsp_checker #(
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_valid_o,
  input logic             motor_up_o,
  input logic             motor_down_o,
  input logic             busy_res_o,
  input logic             done_res_o,
  input logic             dropped_o,
  input logic [CNT_W-1:0] queue_count_o
);

  // An accepted transaction is followed by work in progress or its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("accepted transaction left no trace");

  // Never drive both directions while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(motor_up_o && motor_down_o))
    else $error("both motor outputs on");

  // A drop only happens with a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dropped_o) |-> (queue_count_o == CNT_W'(QUEUE_DEPTH)))
    else $error("drop without full queue");

  // A finished run leaves the motor off and the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && done_res_o) |-> (!busy_res_o && !motor_up_o && !motor_down_o))
    else $error("finished run still driving");

  // Drop and done never come from the same transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(dropped_o && done_res_o))
    else $error("drop and done on one transaction");

endmodule

bind timed_shutter_positioner_core tsp_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tsp_checker (.*);
